>>> rtl/dcs_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dcs_pkg: shared types and constants for the distance constraint solver
// Item and result structs plus the widths of the sqrt and divide cell chains.
// ---------------------------------------------------------------------------
package dcs_pkg;

	localparam int unsigned FracBits = 16;
	localparam int unsigned PosW     = 32;
	localparam int unsigned DiffW    = 33;
	localparam int unsigned MagW     = 32;   // magnitude of a 33 bit signed diff fits 32 bits
	localparam int unsigned SqW      = 65;   // ux^2 + uy^2
	localparam int unsigned RootW    = 33;   // root below 2^33
	localparam int unsigned NumW     = MagW + FracBits;   // |a| * 2^F
	localparam int unsigned QuoW     = NumW;              // quotient bits produced
	localparam int unsigned NW       = FracBits + 2;      // signed direction, |n| <= 2^F
	localparam int unsigned DeltaW   = 35;
	localparam int unsigned ProdW    = NW + DeltaW;

	typedef struct packed {
		logic signed [PosW-1:0] first_x;
		logic signed [PosW-1:0] first_y;
		logic signed [PosW-1:0] second_x;
		logic signed [PosW-1:0] second_y;
		logic                   first_movable;
		logic                   second_movable;
		logic [30:0]            rest_length;
	} item_t;

	typedef struct packed {
		logic signed [PosW-1:0] new_first_x;
		logic signed [PosW-1:0] new_first_y;
		logic signed [PosW-1:0] new_second_x;
		logic signed [PosW-1:0] new_second_y;
	} result_t;

	// square root cell state, res ends up as the root
	typedef struct packed {
		logic             vld;
		item_t            item;
		logic [MagW-1:0]  ux;
		logic [MagW-1:0]  uy;
		logic             nx_neg;
		logic             ny_neg;
		logic [SqW-1:0]   rem;
		logic [SqW-1:0]   res;
	} sq_cell_t;

	// divide cell state, both components share the divisor
	typedef struct packed {
		logic             vld;
		item_t            item;
		logic             nx_neg;
		logic             ny_neg;
		logic [RootW-1:0] span;
		logic [NumW-1:0]  numx;
		logic [NumW-1:0]  numy;
		logic [RootW:0]   remx;
		logic [RootW:0]   remy;
		logic [QuoW-1:0]  qx;
		logic [QuoW-1:0]  qy;
	} dv_cell_t;

	function automatic logic signed [PosW-1:0] sat32(input logic signed [PosW+1:0] v);
		logic signed [PosW+1:0] hi;
		logic signed [PosW+1:0] lo;
		hi = (PosW+2)'(signed'({1'b0, {(PosW-1){1'b1}}}));
		lo = -hi - (PosW+2)'(1);
		if (v > hi)
			return hi[PosW-1:0];
		else if (v < lo)
			return lo[PosW-1:0];
		return v[PosW-1:0];
	endfunction

endpackage
`default_nettype wire

>>> rtl/dcs_sqrt_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dcs_sqrt_cell: one bit of the restoring square root
// Decides one root bit per cell and passes the partial result on.
// ---------------------------------------------------------------------------
module dcs_sqrt_cell (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire [dcs_pkg::SqW-1:0]        one,
	input  wire dcs_pkg::sq_cell_t        cin,
	output dcs_pkg::sq_cell_t             cout
);

	dcs_pkg::sq_cell_t nxt;
	logic [dcs_pkg::SqW:0] trial;

	// one is 4^b for this cell's root bit, res holds the root scaled by 2^(b+1)
	always_comb begin
		nxt = cin;
		trial = {1'b0, cin.res} + {1'b0, one};
		nxt.res = cin.res >> 1;
		if (trial <= {1'b0, cin.rem}) begin
			nxt.rem = cin.rem - trial[dcs_pkg::SqW-1:0];
			nxt.res = (cin.res >> 1) + one;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cout <= '0;
		end else begin
			cout <= nxt;
		end
	end

endmodule
`default_nettype wire

>>> rtl/dcs_div_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dcs_div_cell: one quotient bit for both direction components
// Restoring division step shared by x and y against the common distance.
// ---------------------------------------------------------------------------
module dcs_div_cell (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire dcs_pkg::dv_cell_t  cin,
	output dcs_pkg::dv_cell_t       cout
);

	dcs_pkg::dv_cell_t nxt;
	logic [dcs_pkg::RootW:0] shx;
	logic [dcs_pkg::RootW:0] shy;
	logic [dcs_pkg::RootW:0] dz;

	always_comb begin
		nxt = cin;
		dz  = {1'b0, cin.span};
		shx = {cin.remx[dcs_pkg::RootW-1:0], cin.numx[dcs_pkg::NumW-1]};
		shy = {cin.remy[dcs_pkg::RootW-1:0], cin.numy[dcs_pkg::NumW-1]};
		nxt.numx = cin.numx << 1;
		nxt.numy = cin.numy << 1;
		nxt.qx   = cin.qx << 1;
		nxt.qy   = cin.qy << 1;
		nxt.remx = shx;
		nxt.remy = shy;
		if (shx >= dz) begin
			nxt.remx  = shx - dz;
			nxt.qx[0] = 1'b1;
		end
		if (shy >= dz) begin
			nxt.remy  = shy - dz;
			nxt.qy[0] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cout <= '0;
		end else begin
			cout <= nxt;
		end
	end

endmodule
`default_nettype wire

>>> rtl/distance_constraint_solve_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// distance_constraint_solve_core: 2D distance constraint for one link
// Moves two bodies along their separation to restore the rest length.
// ---------------------------------------------------------------------------
// Usage: drive item with start high; the item is taken at any edge where
// busy is low. busy is tied low, so one link can enter every cycle.
// Each link yields one result on result, flagged by done for one cycle.
// Path: a difference register, a square register, 33 square root cells,
// 48 divide cells, then registers for direction and delta, multiply, scale,
// position update and saturation; done is registered together with result.
// Throughput: one link per cycle, set by the chains of pipelined cells,
// each cell resolving one root bit or one quotient bit per cycle.
// The receiver cannot stall; results are shown once and must be taken.
// Reset clears all valid flags; links in flight are dropped.
// ---------------------------------------------------------------------------
module distance_constraint_solve_core (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	output logic                    busy,
	input  wire dcs_pkg::item_t     item,
	output logic                    done,
	output dcs_pkg::result_t        result
);

	localparam int unsigned Nsq = dcs_pkg::RootW;
	localparam int unsigned Ndv = dcs_pkg::QuoW;

	dcs_pkg::sq_cell_t sq [Nsq+1];
	dcs_pkg::dv_cell_t dv [Ndv+1];

	logic                             vld_s1;
	dcs_pkg::item_t                   item_s1;
	logic signed [dcs_pkg::DiffW-1:0] ax_s1, ay_s1;
	logic [dcs_pkg::MagW-1:0]         ux, uy;
	logic [2*dcs_pkg::MagW-1:0]       uxx, uyy;
	dcs_pkg::sq_cell_t                sq_in_s2;
	dcs_pkg::dv_cell_t                dv_in;
	dcs_pkg::dv_cell_t                dend;

	logic                                vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	dcs_pkg::item_t                      item_s3, item_s4, item_s5, item_s6;
	logic signed [dcs_pkg::NW-1:0]       nx_s3, ny_s3;
	logic signed [dcs_pkg::DeltaW-1:0]   delta_s3;
	logic signed [dcs_pkg::ProdW-1:0]    px_s4, py_s4;
	logic signed [dcs_pkg::ProdW-1:0]    cx_s5, cy_s5;
	logic signed [dcs_pkg::PosW+1:0]     fx_s6, fy_s6, sx_s6, sy_s6;
	logic [dcs_pkg::NW-1:0]              qxe, qye;

	function automatic logic signed [dcs_pkg::ProdW-1:0] tdiv(
		input logic signed [dcs_pkg::ProdW-1:0] p, input logic full);
		logic signed [dcs_pkg::ProdW-1:0] bias;
		bias = full ? (dcs_pkg::ProdW)'((1 << dcs_pkg::FracBits) - 1)
			: (dcs_pkg::ProdW)'((1 << (dcs_pkg::FracBits + 1)) - 1);
		if (p < 0)
			p = p + bias;
		return full ? (p >>> dcs_pkg::FracBits) : (p >>> (dcs_pkg::FracBits + 1));
	endfunction

	// add and clamp the correction into a 34 bit range before final saturation
	function automatic logic signed [dcs_pkg::PosW+1:0] clampadd(
		input logic signed [dcs_pkg::PosW-1:0] pos, input logic signed [dcs_pkg::ProdW-1:0] c);
		logic signed [dcs_pkg::ProdW:0] s;
		s = (dcs_pkg::ProdW+1)'(pos) + (dcs_pkg::ProdW+1)'(c);
		if (s > (dcs_pkg::ProdW+1)'(64'sd4294967295))
			return (dcs_pkg::PosW+2)'(64'sd4294967295);
		if (s < -(dcs_pkg::ProdW+1)'(64'sd4294967296))
			return (dcs_pkg::PosW+2)'(-64'sd4294967296);
		return s[dcs_pkg::PosW+1:0];
	endfunction

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item;
		ax_s1   <= (dcs_pkg::DiffW)'(item.first_x) - (dcs_pkg::DiffW)'(item.second_x);
		ay_s1   <= (dcs_pkg::DiffW)'(item.first_y) - (dcs_pkg::DiffW)'(item.second_y);
	end

	// squares are registered ahead of the first root cell
	assign ux  = ax_s1[dcs_pkg::DiffW-1] ? (dcs_pkg::MagW)'(-ax_s1) : ax_s1[dcs_pkg::MagW-1:0];
	assign uy  = ay_s1[dcs_pkg::DiffW-1] ? (dcs_pkg::MagW)'(-ay_s1) : ay_s1[dcs_pkg::MagW-1:0];
	assign uxx = ux * ux;
	assign uyy = uy * uy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_in_s2 <= '0;
		end else begin
			sq_in_s2.vld    <= vld_s1;
			sq_in_s2.item   <= item_s1;
			sq_in_s2.ux     <= ux;
			sq_in_s2.uy     <= uy;
			sq_in_s2.nx_neg <= ax_s1[dcs_pkg::DiffW-1];
			sq_in_s2.ny_neg <= ay_s1[dcs_pkg::DiffW-1];
			sq_in_s2.rem    <= {1'b0, uxx} + {1'b0, uyy};
			sq_in_s2.res    <= '0;
		end
	end

	assign sq[0] = sq_in_s2;

	for (genvar g = 0; g < Nsq; g++) begin : g_sq
		dcs_sqrt_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.one((dcs_pkg::SqW)'(1) << (2 * (Nsq - 1 - g))),
			.cin(sq[g]), .cout(sq[g+1])
		);
	end

	always_comb begin
		dv_in.vld    = sq[Nsq].vld;
		dv_in.item   = sq[Nsq].item;
		dv_in.nx_neg = sq[Nsq].nx_neg;
		dv_in.ny_neg = sq[Nsq].ny_neg;
		dv_in.span   = sq[Nsq].res[dcs_pkg::RootW-1:0];
		dv_in.numx   = {sq[Nsq].ux, {dcs_pkg::FracBits{1'b0}}};
		dv_in.numy   = {sq[Nsq].uy, {dcs_pkg::FracBits{1'b0}}};
		dv_in.remx   = '0;
		dv_in.remy   = '0;
		dv_in.qx     = '0;
		dv_in.qy     = '0;
	end

	assign dv[0] = dv_in;

	for (genvar g = 0; g < Ndv; g++) begin : g_dv
		dcs_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .cin(dv[g]), .cout(dv[g+1])
		);
	end

	// end of the divide chain; the signed direction, zero when the bodies coincide, is formed from it
	assign dend = dv[Ndv];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s3 <= dend.vld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// the quotient never exceeds 2^F, so its low bits carry all of it
	assign qxe = {1'b0, dend.qx[dcs_pkg::NW-2:0]};
	assign qye = {1'b0, dend.qy[dcs_pkg::NW-2:0]};

	always_ff @(posedge clk) begin
		item_s3  <= dend.item;
		nx_s3    <= (dend.span == '0) ? '0 : (dend.nx_neg ? -signed'(qxe) : signed'(qxe));
		ny_s3    <= (dend.span == '0) ? '0 : (dend.ny_neg ? -signed'(qye) : signed'(qye));
		delta_s3 <= signed'((dcs_pkg::DeltaW)'(dend.item.rest_length))
			- signed'((dcs_pkg::DeltaW)'(dend.span));
		// products: nx is within 2^16 so each is an 18 by 35 multiply
		item_s4 <= item_s3;
		px_s4   <= (dcs_pkg::ProdW)'(nx_s3) * (dcs_pkg::ProdW)'(delta_s3);
		py_s4   <= (dcs_pkg::ProdW)'(ny_s3) * (dcs_pkg::ProdW)'(delta_s3);
		// truncating shift toward zero, full or half
		item_s5 <= item_s4;
		cx_s5   <= tdiv(px_s4, !(item_s4.first_movable && item_s4.second_movable));
		cy_s5   <= tdiv(py_s4, !(item_s4.first_movable && item_s4.second_movable));
		item_s6 <= item_s5;
		if (!item_s5.first_movable) begin
			fx_s6 <= (dcs_pkg::PosW+2)'(item_s5.first_x);
			fy_s6 <= (dcs_pkg::PosW+2)'(item_s5.first_y);
			sx_s6 <= clampadd(item_s5.second_x, -cx_s5);
			sy_s6 <= clampadd(item_s5.second_y, -cy_s5);
		end else if (!item_s5.second_movable) begin
			fx_s6 <= clampadd(item_s5.first_x, cx_s5);
			fy_s6 <= clampadd(item_s5.first_y, cy_s5);
			sx_s6 <= (dcs_pkg::PosW+2)'(item_s5.second_x);
			sy_s6 <= (dcs_pkg::PosW+2)'(item_s5.second_y);
		end else begin
			fx_s6 <= clampadd(item_s5.first_x, cx_s5);
			fy_s6 <= clampadd(item_s5.first_y, cy_s5);
			sx_s6 <= clampadd(item_s5.second_x, -cx_s5);
			sy_s6 <= clampadd(item_s5.second_y, -cy_s5);
		end
		result.new_first_x  <= dcs_pkg::sat32(fx_s6);
		result.new_first_y  <= dcs_pkg::sat32(fy_s6);
		result.new_second_x <= dcs_pkg::sat32(sx_s6);
		result.new_second_y <= dcs_pkg::sat32(sy_s6);
	end

	assign done = vld_s7;

endmodule
`default_nettype wire

>>> rtl/dcs_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dcs_checker: port level checks on the constraint solver
// Watches start, busy and done for transaction ordering, and result for unknown values.
// ---------------------------------------------------------------------------
module dcs_checker (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   start,
	input wire                   busy,
	input wire                   done,
	input wire dcs_pkg::result_t result
);

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy asserted");

	a_done_known: assert property (@(posedge clk) disable iff (!arst_n) !$isunknown(done))
		else $error("done unknown");

	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 88))
		else $error("result without transaction");

	a_result_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(result))
		else $error("result unknown");

endmodule

bind distance_constraint_solve_core dcs_checker u_dcs_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .result(result)
);
`default_nettype wire
